@@ hw/rtl/dsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dsp_pkg;
    localparam int Nodes    = 16;
    localparam int MaxEdges = 64;
    localparam int NodeW    = 4;
    localparam int EdgeW    = 6;
    localparam int CountW   = 7;
    localparam int WtW      = 16;
    localparam int DistW    = 20;
    localparam logic [DistW-1:0] DistMax = '1;

    localparam logic OpAdd = 1'b0;
    localparam logic OpRun = 1'b1;

    typedef struct packed {
        logic             op;
        logic [NodeW-1:0] from_node;
        logic [NodeW-1:0] to_node;
        logic             one_way;
        logic [WtW-1:0]   edge_weight;
        logic [NodeW-1:0] start_node;
    } t_in_item;

    typedef struct packed {
        logic [NodeW-1:0] node_index;
        logic [DistW-1:0] distance;
        logic             reachable;
        logic             status;
        logic             last;
    } t_out_item;

    // Command handed from the front part to the back part.
    typedef struct packed {
        logic             run;
        logic             full;
        logic             one_way;
        logic [NodeW-1:0] from_node;
        logic [NodeW-1:0] to_node;
        logic [WtW-1:0]   edge_weight;
        logic [NodeW-1:0] start_node;
    } t_cmd;
endpackage
`default_nettype wire

@@ hw/rtl/dsp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dsp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire dsp_pkg::t_in_item i_item,
    output logic               o_cmd_valid,
    output dsp_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_take
);
    import dsp_pkg::*;

    // Two-entry command queue.
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [CountW-1:0] r_used;
    logic [CountW-1:0] n_need;
    logic acc, fits;
    t_cmd cmd;

    assign o_full      = (r_cnt == 2'd2);
    assign acc         = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Classify: the front keeps its own count of table entries in use.
    always_comb begin
        n_need = i_item.one_way ? CountW'(1) : CountW'(2);
        fits   = ({1'b0, r_used} + {1'b0, n_need}) <= (CountW+1)'(MaxEdges);
        cmd.run         = (i_item.op == OpRun);
        cmd.full        = !fits;
        cmd.one_way     = i_item.one_way;
        cmd.from_node   = i_item.from_node;
        cmd.to_node     = i_item.to_node;
        cmd.edge_weight = i_item.edge_weight;
        cmd.start_node  = i_item.start_node;
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0; r_used <= '0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
                if (!cmd.run && fits) r_used <= r_used + n_need;
            end
            if (i_cmd_take && o_cmd_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, i_cmd_take && o_cmd_valid};
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CountW'(MaxEdges)) else $error("edge count overflow");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_cmd_valid) else $error("take from empty queue");
endmodule
`default_nettype wire

@@ hw/rtl/dsp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dsp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire dsp_pkg::t_cmd i_cmd,
    output logic               o_cmd_take,
    output logic               o_empty,
    output dsp_pkg::t_out_item o_item,
    input  wire logic          i_pop
);
    import dsp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ADD2  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_PICK  = 8'b0000_1000,
        S_EDGE  = 8'b0001_0000,
        S_RELAX = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state r_st;
    // Edge table memory, one packed word per entry.
    logic [2*NodeW+WtW-1:0] r_mem [MaxEdges];
    logic [2*NodeW+WtW-1:0] r_rd;
    logic [CountW-1:0] r_count;
    t_cmd r_cmd;

    logic [DistW-1:0] r_dist [Nodes];
    logic [Nodes-1:0] r_reach, r_done;
    logic [NodeW-1:0] r_i, r_best;
    logic             r_found;
    logic [CountW-1:0] r_e;
    logic [DistW-1:0] r_bdist;
    t_out_item r_out;
    logic      r_ov;

    logic [NodeW-1:0] rd_src, rd_dst;
    logic [WtW-1:0]   rd_wt;
    logic [DistW:0]   sum;
    logic [DistW-1:0] nd;
    logic             cand, out_free, load_out;

    assign o_empty    = !r_ov;
    assign o_item     = r_out;
    assign out_free   = !r_ov || i_pop;
    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid;
    assign load_out   = ((r_st == S_RESP) || (r_st == S_EMIT)) && out_free;

    assign {rd_src, rd_dst, rd_wt} = r_rd;
    assign sum  = {1'b0, r_bdist} + (DistW+1)'(rd_wt);
    assign nd   = sum[DistW] ? DistMax : sum[DistW-1:0];
    assign cand = r_reach[r_i] && !r_done[r_i] &&
                  (!r_found || r_dist[r_i] < r_dist[r_best]);

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_e[EdgeW-1:0]];
        if (r_st == S_IDLE && i_cmd_valid && !i_cmd.run && !i_cmd.full) begin
            r_mem[r_count[EdgeW-1:0]] <= {i_cmd.from_node, i_cmd.to_node,
                                          i_cmd.edge_weight};
        end else if (r_st == S_ADD2) begin
            r_mem[r_count[EdgeW-1:0]] <= {r_cmd.to_node, r_cmd.from_node,
                                          r_cmd.edge_weight};
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_count <= '0; r_ov <= 1'b0;
            r_reach <= '0; r_done <= '0;
        end else begin
            // The output register fills on a load and drains on a pop.
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_pop && r_ov) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.run) begin
                            r_reach <= (32'(i_cmd.start_node) < Nodes) ?
                                       (Nodes'(1) << i_cmd.start_node) : '0;
                            r_done  <= '0;
                            r_i     <= '0;
                            r_found <= 1'b0;
                            if (32'(i_cmd.start_node) < Nodes) begin
                                r_dist[i_cmd.start_node]  <= '0;
                            end
                            r_st <= S_SCAN;
                        end else if (!i_cmd.full) begin
                            r_count <= r_count + CountW'(1);
                            r_st <= i_cmd.one_way ? S_RESP : S_ADD2;
                        end else begin
                            r_st <= S_RESP;
                        end
                    end
                end
                S_ADD2: begin
                    r_count <= r_count + CountW'(1);
                    r_st <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out <= '{node_index: '0, distance: '0, reachable: 1'b0,
                                   status: r_cmd.full, last: 1'b1};
                        r_st <= S_IDLE;
                    end
                end
                // Sweep for the unvisited reached node of least distance.
                S_SCAN: begin
                    if (cand) begin
                        r_best <= r_i; r_found <= 1'b1;
                    end
                    r_i <= r_i + NodeW'(1);
                    if (r_i == NodeW'(Nodes-1)) r_st <= S_PICK;
                end
                S_PICK: begin
                    r_i <= '0;
                    if (!r_found) begin
                        r_st <= S_EMIT;
                    end else begin
                        r_done[r_best] <= 1'b1;
                        r_bdist <= r_dist[r_best];
                        r_e <= '0;
                        r_st <= S_EDGE;
                    end
                end
                // Memory read latency stage.
                S_EDGE: begin
                    r_st <= (r_e < r_count) ? S_RELAX : S_SCAN;
                    r_found <= 1'b0;
                end
                S_RELAX: begin
                    if (rd_src == r_best && 32'(rd_dst) < Nodes &&
                        (!r_reach[rd_dst] || nd < r_dist[rd_dst])) begin
                        r_dist[rd_dst]  <= nd;
                        r_reach[rd_dst] <= 1'b1;
                    end
                    r_e <= r_e + CountW'(1);
                    r_st <= S_EDGE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out <= '{node_index: r_i,
                                   distance: r_reach[r_i] ? r_dist[r_i] : '0,
                                   reachable: r_reach[r_i], status: 1'b0,
                                   last: r_i == NodeW'(Nodes-1)};
                        r_i <= r_i + NodeW'(1);
                        if (r_i == NodeW'(Nodes-1)) r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(MaxEdges)) else $error("table count overflow");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> r_st == S_IDLE) else $error("command taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_pop |=> r_ov && $stable(r_out))
        else $error("waiting result changed");
endmodule
`default_nettype wire

@@ hw/rtl/dijkstra_shortest_paths.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shortest-path engine over a 64-entry edge table and 16 nodes. An add-edge
// item yields one result, also when the reverse edge is stored too; a run
// yields 16 results, and its time is set by the node scan sweep and the walk
// of the edge memory, plus any time the receiver holds off a waiting result.
// A two-entry command queue lets items be pushed while a run is in progress.
module dijkstra_shortest_paths (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire dsp_pkg::t_in_item i_item,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output dsp_pkg::t_out_item     o_item
);
    import dsp_pkg::*;

    logic cmd_valid, cmd_take;
    t_cmd cmd;

    dsp_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_item,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    dsp_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .o_empty, .o_item, .i_pop
    );
endmodule
`default_nettype wire
